@@ hw/rtl/fpmac_pkg.sv @@
// Shared types, codes and widths for the fixed-point MAC accumulator.
// Used by fpmac_mult, fpmac_acc and fixed_point_mac_accumulator; no dependencies.
`default_nettype none

package fpmac_pkg;

  // Field widths.
  localparam int unsigned OpW      = 3;
  localparam int unsigned FactorW  = 32;
  localparam int unsigned AccW     = 64;
  localparam int unsigned ExportW  = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 2;

  // Operations.
  localparam logic [OpW-1:0] OP_CLEAR  = 3'd0;
  localparam logic [OpW-1:0] OP_IMPORT = 3'd1;
  localparam logic [OpW-1:0] OP_MAC    = 3'd2;
  localparam logic [OpW-1:0] OP_MSUB   = 3'd3;
  localparam logic [OpW-1:0] OP_ADD    = 3'd4;
  localparam logic [OpW-1:0] OP_EXPORT = 3'd5;

  // Number modes.
  localparam logic [1:0] MODE_Q15      = 2'd0;
  localparam logic [1:0] MODE_Q31_FULL = 2'd1;
  localparam logic [1:0] MODE_Q31_HIGH = 2'd2;
  localparam logic [1:0] MODE_RSVD     = 2'd3;

  // Export rounding.
  localparam logic [1:0] RND_FLOOR = 2'd0;
  localparam logic [1:0] RND_ZERO  = 2'd1;
  localparam logic [1:0] RND_EVEN  = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_NUMBER_MODE     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_UPDATE_SATURATE = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_EXPORT_ROUNDING = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_EXPORT_SATURATE = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_EXPORT_NARROW   = 3'd4;

  // Active configuration; mode is already folded so that the reserved code reads as Q15.
  typedef struct packed {
    logic [1:0] mode;
    logic       update_sat;
    logic [1:0] rounding;
    logic       export_sat;
    logic       narrow_q30;
  } cfg_t;

  // One accepted input beat.
  typedef struct packed {
    logic [OpW-1:0]            op;
    logic signed [FactorW-1:0] a;
    logic signed [FactorW-1:0] b;
    logic signed [AccW-1:0]    term;
  } item_t;

  // Item after the multiplier stage.
  typedef struct packed {
    logic [OpW-1:0]            op;
    logic signed [FactorW-1:0] a;
    logic signed [AccW-1:0]    term;
    logic signed [AccW-1:0]    product;
  } prod_t;

endpackage

`default_nettype wire

@@ hw/rtl/fpmac_mult.sv @@
// Multiplier stage: one signed 32x32 product, shaped per number mode and registered.
// Depends on fpmac_pkg.
`default_nettype none

module fpmac_mult (
  input  logic             clk,
  input  logic             load,
  input  fpmac_pkg::cfg_t  cfg,
  input  fpmac_pkg::item_t item,
  output fpmac_pkg::prod_t stage_r
);
  import fpmac_pkg::*;

  logic signed [FactorW-1:0] fa;
  logic signed [FactorW-1:0] fb;
  logic signed [AccW-1:0]    full;
  prod_t                     stage_nxt;

  // Q15 uses the signed low halves; the product then fits easily in 64 bits.
  always_comb begin
    if (cfg.mode == MODE_Q15) begin
      fa = {{16{item.a[15]}}, item.a[15:0]};
      fb = {{16{item.b[15]}}, item.b[15:0]};
    end else begin
      fa = item.a;
      fb = item.b;
    end
  end

  assign full = AccW'(fa) * AccW'(fb);

  always_comb begin
    stage_nxt.op   = item.op;
    stage_nxt.a    = item.a;
    stage_nxt.term = item.term;
    case (cfg.mode)
      MODE_Q31_HIGH: stage_nxt.product = {{32{full[63]}}, full[63:32]};
      default:       stage_nxt.product = full;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/fpmac_acc.sv @@
// Accumulator stage: exact update with wrap or clamp, import, clear and rounded export.
// Holds the accumulator and the export result register. Depends on fpmac_pkg.
`default_nettype none

module fpmac_acc (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load,
  input  fpmac_pkg::cfg_t                      cfg,
  input  fpmac_pkg::prod_t                     stage,
  output logic signed [fpmac_pkg::AccW-1:0]    acc_r,
  output logic signed [fpmac_pkg::ExportW-1:0] export_r
);
  import fpmac_pkg::*;

  logic                      wide;
  logic                      q15;
  logic signed [AccW-1:0]    acc_in;
  logic signed [AccW-1:0]    addend;
  logic        [AccW:0]      sum_x;
  logic signed [AccW-1:0]    wrapped;
  logic signed [AccW-1:0]    clamped;
  logic signed [AccW-1:0]    updated;
  logic signed [AccW-1:0]    imported;
  logic signed [AccW-1:0]    acc_nxt;
  logic signed [AccW-1:0]    q;
  logic signed [AccW-1:0]    q_rnd;
  logic                      shifted;
  logic                      rem_top;
  logic                      rem_low_nz;
  logic                      inc;
  logic signed [ExportW-1:0] narrowed;
  logic signed [ExportW-1:0] export_nxt;

  assign wide = (cfg.mode == MODE_Q31_FULL);
  assign q15  = !wide && !cfg.narrow_q30;

  // In 40-bit modes only the low 40 bits count.
  assign acc_in = wide ? acc_r : {{24{acc_r[39]}}, acc_r[39:0]};
  assign addend = (stage.op == OP_ADD) ? stage.term : stage.product;

  // Exact sum on 65 bits, then wrap or clamp to the accumulator width.
  always_comb begin
    if (stage.op == OP_MSUB) begin
      sum_x = {acc_in[63], acc_in} - {addend[63], addend};
    end else begin
      sum_x = {acc_in[63], acc_in} + {addend[63], addend};
    end
  end

  always_comb begin
    if (wide) begin
      wrapped = sum_x[63:0];
      if (sum_x[64] != sum_x[63]) begin
        clamped = sum_x[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
        clamped = sum_x[63:0];
      end
    end else begin
      wrapped = {{24{sum_x[39]}}, sum_x[39:0]};
      if (!((&sum_x[64:39]) || !(|sum_x[64:39]))) begin
        clamped = sum_x[64] ? {{25{1'b1}}, 39'd0} : {25'd0, {39{1'b1}}};
      end else begin
        clamped = sum_x[63:0];
      end
    end
    updated = cfg.update_sat ? clamped : wrapped;
  end

  always_comb begin
    if (wide) begin
      imported = {stage.a[31], stage.a, 31'd0};
    end else if (q15) begin
      imported = {{33{stage.a[15]}}, stage.a[15:0], 15'd0};
    end else begin
      imported = {{32{stage.a[31]}}, stage.a};
    end
  end

  always_comb begin
    case (stage.op)
      OP_CLEAR:                acc_nxt = '0;
      OP_IMPORT:               acc_nxt = imported;
      OP_MAC, OP_MSUB, OP_ADD: acc_nxt = updated;
      default:                 acc_nxt = acc_in;
    endcase
  end

  // Export: arithmetic shift to the destination fraction, round, then narrow.
  always_comb begin
    if (wide) begin
      q          = {{31{acc_in[63]}}, acc_in[63:31]};
      shifted    = 1'b1;
      rem_top    = acc_in[30];
      rem_low_nz = |acc_in[29:0];
    end else if (q15) begin
      q          = {{15{acc_in[63]}}, acc_in[63:15]};
      shifted    = 1'b1;
      rem_top    = acc_in[14];
      rem_low_nz = |acc_in[13:0];
    end else begin
      q          = acc_in;
      shifted    = 1'b0;
      rem_top    = 1'b0;
      rem_low_nz = 1'b0;
    end
    case (cfg.rounding)
      RND_FLOOR: inc = 1'b0;
      RND_ZERO:  inc = shifted && acc_in[63] && (rem_top || rem_low_nz);
      default:   inc = shifted && rem_top && (rem_low_nz || q[0]);
    endcase
    q_rnd = q + {63'd0, inc};
  end

  always_comb begin
    if (q15) begin
      if (cfg.export_sat && !((&q_rnd[63:15]) || !(|q_rnd[63:15]))) begin
        narrowed = q_rnd[63] ? {{17{1'b1}}, 15'd0} : {17'd0, {15{1'b1}}};
      end else begin
        narrowed = {{16{q_rnd[15]}}, q_rnd[15:0]};
      end
    end else begin
      if (cfg.export_sat && !((&q_rnd[63:31]) || !(|q_rnd[63:31]))) begin
        narrowed = q_rnd[63] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
      end else begin
        narrowed = q_rnd[31:0];
      end
    end
    export_nxt = (stage.op == OP_EXPORT) ? narrowed : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (load) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      export_r <= export_nxt;
    end
  end

  a_export_keeps_acc: assert property (@(posedge clk) disable iff (!rst_n)
    load && (stage.op == OP_EXPORT) |=> acc_r == $past(acc_in))
    else $error("export changed the accumulator");

  a_export_zero: assert property (@(posedge clk) disable iff (!rst_n)
    load && (stage.op != OP_EXPORT) |=> export_r == '0)
    else $error("export value not zero for a non-export operation");

  a_narrow_sext: assert property (@(posedge clk) disable iff (!rst_n)
    load && !wide |=> ((&acc_r[63:39]) || !(|acc_r[63:39])))
    else $error("40-bit accumulator not sign-extended");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    load && (stage.op == OP_CLEAR) |=> acc_r == '0)
    else $error("clear left a non-zero accumulator");

endmodule

`default_nettype wire

@@ hw/rtl/fixed_point_mac_accumulator.sv @@
// Top level of the signed fixed-point MAC accumulator: stream ports, configuration
// registers, the input register and the stage handshake. Uses fpmac_pkg, fpmac_mult, fpmac_acc.
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+----------------------------------------
//   in_     | slave     | in_tvalid / in_tready   | tuser: operation; tdata: a, b, term
//   out_    | master    | out_tvalid / out_tready | tdata: accumulator_value, export_value
//   cfg_    | write     | cfg_we                  | cfg_index, cfg_wdata
//
// One beat is accepted every cycle when the result side keeps up; each beat gives exactly
// one result beat, after the input register, the multiplier register and the accumulator.
// The throughput is set by the accumulator feedback, one 65-bit add and clamp per cycle.
// Reset is synchronous and active low; it empties the pipeline, zeroes the accumulator
// and loads the register defaults. A stall on out_tready holds every full stage in place
// while empty stages still fill, so in_tready only drops when all three stages are full.
`default_nettype none

module fixed_point_mac_accumulator (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [127:0]                      in_tdata,   // multiplier_a, multiplier_b, addend_term
  input  logic [fpmac_pkg::OpW-1:0]         in_tuser,   // operation
  // Result stream.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [95:0]                       out_tdata,  // accumulator_value, export_value
  // Configuration writes.
  input  logic                              cfg_we,
  input  logic [fpmac_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [fpmac_pkg::CfgDataW-1:0]    cfg_wdata
);
  import fpmac_pkg::*;

  // Configuration registers.
  logic [1:0] mode_r,        mode_nxt;
  logic       update_sat_r,  update_sat_nxt;
  logic [1:0] rounding_r,    rounding_nxt;
  logic       export_sat_r,  export_sat_nxt;
  logic       narrow_r,      narrow_nxt;
  cfg_t       cfg;

  // Pipeline control.
  logic  s1_valid_r,  s1_valid_nxt;
  logic  s2_valid_r,  s2_valid_nxt;
  logic  out_valid_r, out_valid_nxt;
  logic  out_free;
  logic  s2_ready;
  logic  in_fire;
  logic  load2;
  logic  load3;
  item_t s1_item_r,   s1_item_nxt;
  prod_t s2_item;

  logic signed [AccW-1:0]    acc_value;
  logic signed [ExportW-1:0] export_value;

  // Register writes; indexes past the list are ignored.
  always_comb begin
    mode_nxt       = mode_r;
    update_sat_nxt = update_sat_r;
    rounding_nxt   = rounding_r;
    export_sat_nxt = export_sat_r;
    narrow_nxt     = narrow_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_NUMBER_MODE:     mode_nxt       = cfg_wdata;
        REG_UPDATE_SATURATE: update_sat_nxt = cfg_wdata[0];
        REG_EXPORT_ROUNDING: rounding_nxt   = cfg_wdata;
        REG_EXPORT_SATURATE: export_sat_nxt = cfg_wdata[0];
        REG_EXPORT_NARROW:   narrow_nxt     = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_Q15;
      update_sat_r <= 1'b0;
      rounding_r   <= RND_EVEN;
      export_sat_r <= 1'b1;
      narrow_r     <= 1'b0;
    end else begin
      mode_r       <= mode_nxt;
      update_sat_r <= update_sat_nxt;
      rounding_r   <= rounding_nxt;
      export_sat_r <= export_sat_nxt;
      narrow_r     <= narrow_nxt;
    end
  end

  // The reserved number mode behaves as Q15.
  assign cfg.mode       = (mode_r == MODE_RSVD) ? MODE_Q15 : mode_r;
  assign cfg.update_sat = update_sat_r;
  assign cfg.rounding   = rounding_r;
  assign cfg.export_sat = export_sat_r;
  assign cfg.narrow_q30 = narrow_r;

  // Each stage moves on when the one after it is empty or emptying this cycle.
  assign out_free  = !out_valid_r || out_tready;
  assign load3     = s2_valid_r && out_free;
  assign s2_ready  = !s2_valid_r || out_free;
  assign load2     = s1_valid_r && s2_ready;
  assign in_tready = !s1_valid_r || s2_ready;
  assign in_fire   = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_fire || (s1_valid_r && !load2);
  assign s2_valid_nxt  = load2 || (s2_valid_r && !load3);
  assign out_valid_nxt = load3 || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register.
  always_comb begin
    s1_item_nxt.op   = in_tuser;
    s1_item_nxt.a    = in_tdata[31:0];
    s1_item_nxt.b    = in_tdata[63:32];
    s1_item_nxt.term = in_tdata[127:64];
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= s1_item_nxt;
    end
  end

  fpmac_mult u_mult (
    .clk     (clk),
    .load    (load2),
    .cfg     (cfg),
    .item    (s1_item_r),
    .stage_r (s2_item)
  );

  // The accumulator doubles as the result's accumulator field: it only changes when a
  // new result is loaded, so it holds steady while a result waits.
  fpmac_acc u_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load3),
    .cfg      (cfg),
    .stage    (s2_item),
    .acc_r    (acc_value),
    .export_r (export_value)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {export_value, acc_value};

endmodule

`default_nettype wire

@@ bench/fixed_point_mac_accumulator_tb.sv @@
// Self-checking bench for the fixed-point MAC accumulator: a scoreboard class predicts
// every result beat, plain tasks drive the input stream and the configuration port.
// Depends on fpmac_pkg and the fixed_point_mac_accumulator top level.
`timescale 1ns / 100ps

module fixed_point_mac_accumulator_tb;
  import fpmac_pkg::*;

  // Reserved codes that the block must tolerate.
  localparam logic [OpW-1:0] OP_RESERVED_LO = 3'd6;
  localparam logic [OpW-1:0] OP_RESERVED_HI = 3'd7;
  localparam logic [1:0]     RND_RESERVED   = 2'd3;

  // Expected content of one result beat.
  typedef struct packed {
    logic signed [63:0] acc;
    logic signed [31:0] exp_val;
  } mac_result_t;

  // Scoreboard: a shadow copy of the accumulator and of the five registers, a
  // predictor that works out the result of each accepted input beat, and the
  // queue of results still owed by the block.
  class mac_scoreboard;
    logic [1:0]         number_mode;
    logic               update_sat;
    logic [1:0]         rounding;
    logic               export_sat;
    logic               narrow_q30;
    logic signed [63:0] acc_shadow;
    mac_result_t        pending_results[$];
    int unsigned        mismatches;

    function new();
      number_mode = MODE_Q15;
      update_sat  = 1'b0;
      rounding    = RND_EVEN;
      export_sat  = 1'b1;
      narrow_q30  = 1'b0;
      acc_shadow  = '0;
      mismatches  = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        REG_NUMBER_MODE:     number_mode = val;
        REG_UPDATE_SATURATE: update_sat  = val[0];
        REG_EXPORT_ROUNDING: rounding    = val;
        REG_EXPORT_SATURATE: export_sat  = val[0];
        REG_EXPORT_NARROW:   narrow_q30  = val[0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // Keep the low w bits and sign-extend them.
    function logic signed [63:0] wrap_to(logic signed [63:0] v, int unsigned w);
      logic signed [63:0] t;
      t = v <<< (64 - w);
      return t >>> (64 - w);
    endfunction

    function logic signed [63:0] clamp_to(logic signed [64:0] v, int unsigned w);
      logic signed [64:0] top;
      logic signed [64:0] bottom;
      top    = (65'sd1 <<< (w - 1)) - 65'sd1;
      bottom = -top - 65'sd1;
      if (v > top) return top[63:0];
      if (v < bottom) return bottom[63:0];
      return v[63:0];
    endfunction

    // The sum is formed exactly in 65 bits, so clamping it is the same as the
    // block's overflow-then-clamp rule.
    function logic signed [63:0] apply_update(logic signed [63:0] acc, logic signed [63:0] rhs,
                                              bit subtract, int unsigned w);
      logic signed [64:0] exact;
      if (subtract) exact = $signed({acc[63], acc}) - $signed({rhs[63], rhs});
      else exact = $signed({acc[63], acc}) + $signed({rhs[63], rhs});
      if (!update_sat) return wrap_to(exact[63:0], w);
      return clamp_to(exact, w);
    endfunction

    function void predict_beat(logic [OpW-1:0] op, logic signed [31:0] a,
                               logic signed [31:0] b, logic signed [63:0] term);
      logic [1:0]         mode;
      int unsigned        accw;
      int unsigned        shift;
      int unsigned        dw;
      bit                 q15;
      bit                 inc;
      logic signed [63:0] acc;
      logic signed [63:0] prod;
      logic signed [63:0] a64;
      logic signed [63:0] b64;
      logic signed [63:0] a16;
      logic signed [63:0] b16;
      logic signed [63:0] q;
      logic [63:0]        rem;
      logic [63:0]        half;
      logic signed [31:0] expv;
      mac_result_t        res;
      mode = (number_mode == MODE_RSVD) ? MODE_Q15 : number_mode;
      accw = (mode == MODE_Q31_FULL) ? 64 : 40;
      q15  = (mode != MODE_Q31_FULL) && !narrow_q30;
      a64  = a;
      b64  = b;
      a16  = $signed(a[15:0]);
      b16  = $signed(b[15:0]);
      // After a mode change only the low 40 bits count in the narrow modes.
      acc  = wrap_to(acc_shadow, accw);
      if (mode == MODE_Q15) prod = a16 * b16;
      else if (mode == MODE_Q31_FULL) prod = a64 * b64;
      else prod = wrap_to((a64 * b64) >>> 32, 32);
      expv = '0;
      case (op)
        OP_CLEAR: acc = '0;
        OP_IMPORT: begin
          if (mode == MODE_Q31_FULL) acc = a64 <<< 31;
          else if (q15) acc = a16 <<< 15;
          else acc = a64;
        end
        OP_MAC:  acc = apply_update(acc, prod, 1'b0, accw);
        OP_MSUB: acc = apply_update(acc, prod, 1'b1, accw);
        OP_ADD:  acc = apply_update(acc, term, 1'b0, accw);
        OP_EXPORT: begin
          shift = (mode == MODE_Q31_FULL) ? 31 : (q15 ? 15 : 0);
          dw    = q15 ? 16 : 32;
          q     = acc >>> shift;
          if (shift != 0 && rounding != RND_FLOOR) begin
            rem  = acc & ((64'd1 << shift) - 64'd1);
            half = 64'd1 << (shift - 1);
            // The reserved rounding code behaves as nearest even.
            if (rounding == RND_ZERO) inc = acc[63] && (rem != 0);
            else inc = (rem > half) || (rem == half && q[0]);
            if (inc) q = q + 64'sd1;
          end
          q    = export_sat ? clamp_to($signed({q[63], q}), dw) : wrap_to(q, dw);
          expv = q[31:0];
        end
        default: ;  // reserved operations leave everything as it is
      endcase
      acc_shadow = wrap_to(acc, accw);
      res.acc     = acc_shadow;
      res.exp_val = expv;
      pending_results.insert(pending_results.size(), res);
    endfunction

    function void check_beat(logic signed [63:0] acc, logic signed [31:0] expv);
      mac_result_t want;
      bit          bad;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result beat with nothing expected: acc %h export %h", $time, acc, expv);
        return;
      end
      want = pending_results.pop_front();
      bad  = 1'b0;
      if (want.acc !== acc) begin
        bad = 1'b1;
        if (mismatches < 10)
          $display("%0t: accumulator_value expected %h got %h", $time, want.acc, acc);
      end
      if (want.exp_val !== expv) begin
        bad = 1'b1;
        if (mismatches < 10)
          $display("%0t: export_value expected %h got %h", $time, want.exp_val, expv);
      end
      if (bad) mismatches++;
    endfunction
  endclass

  localparam int unsigned HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int unsigned WATCHDOG_LIMIT = 3000;  // cycles without any accepted beat
  localparam int unsigned PHASES         = 12;
  localparam int unsigned PHASE_ITEMS    = 146;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [127:0]         in_tdata;   // multiplier_a, multiplier_b, addend_term
  logic [OpW-1:0]       in_tuser;   // operation
  logic                 out_tvalid;
  logic                 out_tready;
  logic [95:0]          out_tdata;  // accumulator_value, export_value
  logic                 cfg_we;
  logic [CfgIdxW-1:0]   cfg_index;
  logic [CfgDataW-1:0]  cfg_wdata;

  mac_scoreboard sb;
  bit            idle_on  = 1'b1;  // random idling on both sides
  bit            hold_req = 1'b0;  // asks the receiver for one long hold-off
  int unsigned   items_sent = 0;
  int unsigned   quiet_cycles = 0;

  fixed_point_mac_accumulator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // 8 ns clock period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Both channels are sampled at the rising edge. The result beat is checked
  // before the input beat of the same edge is predicted, although with the
  // block's latency the two can never refer to the same item.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_beat(out_tdata[63:0], out_tdata[95:64]);
      if (in_tvalid && in_tready)
        sb.predict_beat(in_tuser, in_tdata[31:0], in_tdata[63:32], in_tdata[127:64]);
    end
  end

  // The watchdog counts cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("fixed_point_mac_accumulator_tb NOT OK");
        $finish;
      end
    end
  end

  // Receiver. It stalls at random while idling is on, and on request holds
  // off for a long stretch so that all three stages fill and in_tready drops
  // while the sender keeps offering beats.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_tready = idle_on ? ($urandom_range(99) >= 18) : 1'b1;
    end
  end

  // Offers one beat, after a random gap, and returns at the edge where it is
  // accepted. The valid stays high into the next call, which either lowers it
  // for a gap or replaces the payload at the following falling edge.
  task automatic send_item(input logic [OpW-1:0] op, input logic [31:0] a,
                           input logic [31:0] b, input logic [63:0] term);
    if (idle_on) begin
      while ($urandom_range(99) < 18) begin
        @(negedge clk);
        in_tvalid = 1'b0;
      end
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {term, b, a};
    items_sent++;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // Every item gives a result, so an empty queue means the pipeline is empty;
  // a few more cycles are left for safety all the same.
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic configure(input logic [1:0] mode, input logic usat, input logic [1:0] rnd,
                           input logic esat, input logic narrow);
    wait_drained();
    write_reg(REG_NUMBER_MODE, mode);
    write_reg(REG_UPDATE_SATURATE, {1'b0, usat});
    write_reg(REG_EXPORT_ROUNDING, rnd);
    write_reg(REG_EXPORT_SATURATE, {1'b0, esat});
    write_reg(REG_EXPORT_NARROW, {1'b0, narrow});
  endtask

  // Factors lean towards the format extremes; the Q15 extremes carry junk in
  // the upper half, which the Q15 mode must ignore.
  function automatic logic [31:0] pick_factor();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_8000 | ($urandom & 32'hFFFF_0000);
      3: return 32'h0000_7FFF | ($urandom & 32'hFFFF_0000);
      4: return 32'h0000_0000;
      5: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Terms span every magnitude; some are exact halves at the Q15 or Q31
  // export position, which give rounding ties after a clear.
  function automatic logic [63:0] pick_term();
    logic signed [63:0] t;
    case ($urandom_range(9))
      0: return 64'h7FFF_FFFF_FFFF_FFFF;
      1: return 64'h8000_0000_0000_0000;
      2: t = (64'($urandom_range(1023)) << 15) | (64'd1 << 14);
      3: t = (64'($urandom_range(1023)) << 31) | (64'd1 << 30);
      default: begin
        t = {$urandom, $urandom};
        t = t >>> $urandom_range(63);
      end
    endcase
    if ($urandom_range(1)) t = -t;
    return t;
  endfunction

  // Mostly well-formed runs: a clear or import, a string of MAC, MSUB and add
  // beats with exports and imports mixed in, and a closing export. The rest is noise that
  // includes the reserved operations.
  task automatic run_sequence();
    int unsigned    n;
    int unsigned    r;
    logic [OpW-1:0] op;
    if ($urandom_range(99) < 15) begin
      n = $urandom_range(8, 1);
      repeat (n) send_item(OpW'($urandom_range(7)), pick_factor(), pick_factor(), pick_term());
    end else begin
      send_item($urandom_range(1) ? OP_CLEAR : OP_IMPORT, pick_factor(), pick_factor(),
                pick_term());
      n = $urandom_range(24, 1);
      repeat (n) begin
        r = $urandom_range(99);
        if (r < 50) op = OP_MAC;
        else if (r < 70) op = OP_MSUB;
        else if (r < 85) op = OP_ADD;
        else if (r < 93) op = OP_EXPORT;
        else op = OP_IMPORT;
        send_item(op, pick_factor(), pick_factor(), pick_term());
      end
      send_item(OP_EXPORT, pick_factor(), pick_factor(), pick_term());
    end
  endtask

  // Short directed part. The accumulator is carried across the mode changes on
  // purpose, so that a 64-bit value is later read back in a 40-bit mode.
  task automatic run_directed();
    // Reset settings: Q15, wrapping updates, nearest even, clamped export.
    send_item(OP_CLEAR, 32'h0, 32'h0, 64'h0);
    send_item(OP_IMPORT, 32'h0000_7FFF, 32'h0, 64'h0);
    send_item(OP_MAC, 32'hFFFF_8000, 32'h1234_8000, 64'h0);
    send_item(OP_EXPORT, 32'h0, 32'h0, 64'h0);
    send_item(OP_MSUB, 32'h0000_7FFF, 32'h0000_8000, 64'h0);
    send_item(OP_ADD, 32'h0, 32'h0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(OP_EXPORT, 32'h0, 32'h0, 64'h0);
    send_item(OP_RESERVED_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OP_RESERVED_HI, 32'h8000_0000, 32'h8000_0000, 64'h8000_0000_0000_0000);
    send_item(OP_ADD, 32'h0, 32'h0, 64'h8000_0000_0000_0000);
    send_item(OP_EXPORT, 32'h0, 32'h0, 64'h0);
    end_burst();
    // Q31 full product, clamped updates, toward zero, wrapped export.
    configure(MODE_Q31_FULL, 1'b1, RND_ZERO, 1'b0, 1'b0);
    send_item(OP_IMPORT, 32'h7FFF_FFFF, 32'h0, 64'h0);
    send_item(OP_MAC, 32'h8000_0000, 32'h8000_0000, 64'h0);
    send_item(OP_EXPORT, 32'h0, 32'h0, 64'h0);
    send_item(OP_MSUB, 32'h7FFF_FFFF, 32'h8000_0000, 64'h0);
    send_item(OP_ADD, 32'h0, 32'h0, 64'h8000_0000_0000_0000);
    send_item(OP_EXPORT, 32'h0, 32'h0, 64'h0);
    end_burst();
    // Q31 high product with Q30 import and export, reserved rounding code.
    configure(MODE_Q31_HIGH, 1'b1, RND_RESERVED, 1'b1, 1'b1);
    send_item(OP_EXPORT, 32'h0, 32'h0, 64'h0);
    send_item(OP_IMPORT, 32'h7FFF_FFFF, 32'h0, 64'h0);
    send_item(OP_MAC, 32'h8000_0000, 32'h8000_0000, 64'h0);
    send_item(OP_ADD, 32'h0, 32'h0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(OP_EXPORT, 32'h0, 32'h0, 64'h0);
    end_burst();
    // Reserved number mode reads as Q15; floor rounding on a negative value.
    configure(MODE_RSVD, 1'b0, RND_FLOOR, 1'b0, 1'b0);
    send_item(OP_IMPORT, 32'hFFFF_8001, 32'h0, 64'h0);
    send_item(OP_ADD, 32'h0, 32'h0, 64'h0000_0000_0000_4000);
    send_item(OP_EXPORT, 32'h0, 32'h0, 64'h0);
    end_burst();
  endtask

  initial begin
    int unsigned phase_target;
    sb         = new();
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = OP_CLEAR;
    cfg_we     = 1'b0;
    cfg_index  = REG_NUMBER_MODE;
    cfg_wdata  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_directed();

    for (int unsigned p = 0; p < PHASES; p++) begin
      // The first four phases walk every register through its extremes; the
      // remaining ones pick settings at random.
      if (p < 4) configure(p[1:0], p[0], 2'(p + 2), ~p[0], p[1]);
      else configure(2'($urandom_range(3)), 1'($urandom_range(1)), 2'($urandom_range(3)),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
      // One stretch without any idling, and one long hold-off by the receiver.
      idle_on = (p != 7);
      if (p == 5) hold_req = 1'b1;
      phase_target = items_sent + PHASE_ITEMS;
      while (items_sent < phase_target) run_sequence();
      end_burst();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("fixed_point_mac_accumulator_tb OK");
    end else begin
      $display("fixed_point_mac_accumulator_tb NOT OK");
    end
    $finish;
  end

endmodule
